// ===== src/csv_field_tokenizer_unit_defines.svh =====
// Assertion macros for the CSV field tokenizer.
// Expects signals clk and rst_n in the scope of use; no other dependencies.
`ifndef CSV_FIELD_TOKENIZER_UNIT_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CSVT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CSVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/csvt_pkg.sv =====
// Shared types and constants of the CSV field tokenizer.
// No dependencies; imported by every module of the block.
package csvt_pkg;

  localparam logic [7:0] QUOTE_BYTE = 8'h22;
  localparam logic [7:0] LF_BYTE    = 8'h0A;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] SEP_RESET  = 8'd44;

  localparam int FIFO_DEPTH_DEF = 4;

  // Event kinds
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_FIELD = 2'd1;
  localparam logic [1:0] KIND_ROW   = 2'd2;

  typedef enum logic [5:0] {
    MODE_ROW   = 6'b000001,
    MODE_FIELD = 6'b000010,
    MODE_UNQ   = 6'b000100,
    MODE_QUO   = 6'b001000,
    MODE_QQ    = 6'b010000,
    MODE_CR    = 6'b100000
  } csvt_mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } csvt_in_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] field_char;
    logic       run_last;
  } csvt_out_t;

  // One or two events caused by one byte
  typedef struct packed {
    logic       two;
    logic [1:0] kind0;
    logic [1:0] kind1;
    logic [7:0] ch;
  } csvt_rec_t;

  typedef struct packed {
    logic      valid;
    csvt_rec_t rec;
  } csvt_push_t;

endpackage

// ===== src/csvt_front.sv =====
// Front end: byte classification, scan mode and event record build.
// Depends on csvt_pkg.
module csvt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  csvt_pkg::csvt_in_t  in_data,
  input  logic                push_ready,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  output logic                in_ready,
  output csvt_pkg::csvt_push_t push,
  output logic                row_start
);
  import csvt_pkg::*;

  csvt_mode_t mode_r, mode_nxt;
  logic [7:0] sep_r;
  logic [7:0] b;
  logic       fin, in_fire;
  logic       is_q, is_cr, is_lf, is_sep, ends;
  csvt_mode_t eof_mode;
  logic [1:0] eof_kind;
  logic [1:0] n;
  logic [1:0] k0, k1;
  logic       stray, start;

  assign b       = in_data.text_byte;
  assign fin     = in_data.final_byte;
  assign in_ready = push_ready;
  assign in_fire = in_valid && in_ready;

  // Classify the byte
  assign is_q   = (b == QUOTE_BYTE);
  assign is_cr  = (b == CR_BYTE);
  assign is_lf  = (b == LF_BYTE);
  assign is_sep = (b == sep_r) && !is_q && !is_cr && !is_lf;
  assign ends   = is_sep || is_cr || is_lf;

  assign eof_mode = is_cr ? MODE_CR : (is_lf ? MODE_ROW : MODE_FIELD);
  assign eof_kind = (is_cr || is_lf) ? KIND_ROW : KIND_FIELD;

  // Next mode and events of this byte
  always_comb begin
    mode_nxt = mode_r;
    n        = 2'd0;
    k0       = KIND_CHAR;
    k1       = KIND_CHAR;
    stray    = 1'b0;
    start    = 1'b0;
    case (mode_r)
      MODE_CR: begin
        if (is_lf) mode_nxt = MODE_ROW;
        else       start    = 1'b1;
      end
      MODE_ROW, MODE_FIELD: begin
        start = 1'b1;
      end
      MODE_UNQ: begin
        n = 2'd1;
        if (ends) begin
          k0       = eof_kind;
          mode_nxt = eof_mode;
        end
      end
      MODE_QUO: begin
        if (is_q) mode_nxt = MODE_QQ;
        else      n        = 2'd1;
      end
      MODE_QQ: begin
        if (is_q) begin
          n        = 2'd1;
          mode_nxt = MODE_QUO;
        end else if (ends) begin
          n        = 2'd1;
          k0       = eof_kind;
          mode_nxt = eof_mode;
        end else if (fin) begin
          // stray byte on the last byte stays in the quoted field
          n     = 2'd2;
          k1    = KIND_ROW;
          stray = 1'b1;
        end else begin
          n        = 2'd2;
          k0       = KIND_FIELD;
          mode_nxt = MODE_UNQ;
        end
      end
      default: begin
        mode_nxt = MODE_ROW;
      end
    endcase

    if (start) begin
      if (is_q) begin
        mode_nxt = MODE_QUO;
      end else if (ends) begin
        n        = 2'd1;
        k0       = eof_kind;
        mode_nxt = eof_mode;
      end else begin
        n        = 2'd1;
        mode_nxt = MODE_UNQ;
      end
    end

    // Close an open field on the last byte
    if (fin) begin
      if (!stray && (mode_nxt inside {MODE_FIELD, MODE_UNQ, MODE_QUO, MODE_QQ})) begin
        if (n == 2'd0) k0 = KIND_ROW;
        else           k1 = KIND_ROW;
        n = n + 2'd1;
      end
      mode_nxt = MODE_ROW;
    end
  end

  // Hand the record to the queue; drop bytes without events
  assign push.valid     = in_valid && (n != 2'd0);
  assign push.rec.two   = (n == 2'd2);
  assign push.rec.kind0 = k0;
  assign push.rec.kind1 = k1;
  assign push.rec.ch    = b;

  assign row_start = (mode_r == MODE_ROW);

  // Advance scan mode, hold separator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ROW;
      sep_r  <= SEP_RESET;
    end else begin
      if (in_fire) mode_r <= mode_nxt;
      if (cfg_we)  sep_r  <= cfg_wdata;
    end
  end

endmodule

// ===== src/csvt_fifo.sv =====
// Short record queue between front and back end.
// Depends on csvt_pkg.
module csvt_fifo #(
  parameter int DEPTH = csvt_pkg::FIFO_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  csvt_pkg::csvt_push_t  push,
  output logic                  push_ready,
  input  logic                  pop,
  output logic                  head_valid,
  output csvt_pkg::csvt_rec_t   head,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  import csvt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  csvt_rec_t        mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign level      = cnt_r;
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  // Store the record word
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push.rec;
  end

endmodule

// ===== src/csvt_back.sv =====
// Back end: splits each record into single events behind an output register.
// Depends on csvt_pkg.
module csvt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  csvt_pkg::csvt_rec_t  head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output csvt_pkg::csvt_out_t  out_data
);
  import csvt_pkg::*;

  logic       out_valid_r;
  csvt_out_t  out_r;
  logic       pend_r;
  logic [1:0] pend_kind_r;
  logic [7:0] pend_ch_r;
  logic       load;

  assign load = !out_valid_r || out_ready;
  assign pop  = load && !pend_r && head_valid;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Control: output valid and pending second event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (load) begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else begin
        out_valid_r <= head_valid;
        pend_r      <= head_valid && head.two;
      end
    end
  end

  // Payload: emit pending event first, else the first event of the head word
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_r) begin
        out_r.event_kind <= pend_kind_r;
        out_r.field_char <= (pend_kind_r == KIND_CHAR) ? pend_ch_r : 8'd0;
        out_r.run_last   <= 1'b1;
      end else begin
        out_r.event_kind <= head.kind0;
        out_r.field_char <= (head.kind0 == KIND_CHAR) ? head.ch : 8'd0;
        out_r.run_last   <= !head.two;
        pend_kind_r      <= head.kind1;
        pend_ch_r        <= head.ch;
      end
    end
  end

endmodule

// ===== src/csv_field_tokenizer_unit.sv =====
// Top level of the CSV field tokenizer: front end, record queue, back end.
// Depends on csvt_pkg, csvt_front, csvt_fifo, csvt_back and the defines header.
//
//  port group  | dir | handshake           | word
//  ------------+-----+---------------------+------------------------------
//  in_*        | in  | in_valid/in_ready   | csvt_in_t: text_byte, final_byte
//  out_*       | out | out_valid/out_ready | csvt_out_t: kind, char, run_last
//  cfg_*       | in  | cfg_we (no wait)    | separator byte
//
// One byte is taken per cycle while the queue has room; a byte is classified
// and queued in the cycle it is taken. The back end sends one event per cycle
// while out_ready allows, so a byte with two events is sent as two output events.
// The first event of a byte is written to the queue when the byte is taken and
// then passes the output register. A stalled output fills the queue and then
// lowers in_ready. Reset (rst_n, synchronous) restores row start and separator 44.
`include "csv_field_tokenizer_unit_defines.svh"

module csv_field_tokenizer_unit #(
  parameter int FIFO_DEPTH = csvt_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  csvt_pkg::csvt_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output csvt_pkg::csvt_out_t out_data,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);
  import csvt_pkg::*;

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  csvt_push_t    push;
  logic          push_ready;
  logic          pop;
  logic          head_valid;
  csvt_rec_t     head;
  logic [CW-1:0] level;
  logic          row_start;
  logic          q_full;
  logic          last_fire;
  logic          ev_ctrl;
  logic          kind_ok;

  csvt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .push_ready (push_ready),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ready   (in_ready),
    .push       (push),
    .row_start  (row_start)
  );

  csvt_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .level      (level)
  );

  csvt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // Terms for the checks
  assign q_full    = (level == CW'(FIFO_DEPTH));
  assign last_fire = in_valid && in_ready && in_data.final_byte;
  assign ev_ctrl   = out_valid && (out_data.event_kind != KIND_CHAR);
  assign kind_ok   = (out_data.event_kind inside {KIND_CHAR, KIND_FIELD, KIND_ROW});

  // Checks
  `CSVT_ASSERT_NOW(a_stall_full, in_valid && !in_ready, q_full, "stall with queue room")
  `CSVT_ASSERT_NEXT(a_final_to_row, last_fire, row_start, "final byte left field open")
  `CSVT_ASSERT_NOW(a_ctrl_char, ev_ctrl, out_data.field_char == 8'd0, "char on control event")
  `CSVT_ASSERT_NOW(a_kind_legal, out_valid, kind_ok, "illegal event kind")

endmodule

// ===== tb/sv/csvt_event_checker.sv =====
// Event checker for the CSV field tokenizer: watches both channels and the
// separator write port, predicts events per accepted word, compares results.
// Depends on csvt_pkg for the word types, byte codes and event kinds.
module csvt_event_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  csvt_pkg::csvt_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  csvt_pkg::csvt_out_t out_data,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import csvt_pkg::*;

  logic [7:0] separator = SEP_RESET;
  csvt_mode_t scan = MODE_ROW;
  csvt_out_t  expected_events[$];
  csvt_out_t  byte_events[$];
  int         fail_total = 0;

  assign fail_count = fail_total;
  assign pending    = expected_events.size();

  function automatic csvt_out_t make_event(logic [1:0] kind, logic [7:0] ch);
    csvt_out_t e;
    e.event_kind = kind;
    e.field_char = (kind == KIND_CHAR) ? ch : 8'd0;
    e.run_last   = 1'b0;
    return e;
  endfunction

  // Append one event to those of the current word
  function automatic void add_event(input csvt_out_t e);
    byte_events = {byte_events, e};
  endfunction

  // Close a field outside quotes on separator, CR or LF
  task automatic close_field(input logic [7:0] b);
    if (b == CR_BYTE) begin
      add_event(make_event(KIND_ROW, 8'd0));
      scan = MODE_CR;
    end else if (b == LF_BYTE) begin
      add_event(make_event(KIND_ROW, 8'd0));
      scan = MODE_ROW;
    end else begin
      add_event(make_event(KIND_FIELD, 8'd0));
      scan = MODE_FIELD;
    end
  endtask

  // Advance the scan state by one word and queue the events it causes
  task automatic predict_events(input csvt_in_t w);
    logic [7:0] b;
    logic       fin;
    logic       is_sep;
    logic       ends;
    logic       stray_done;
    csvt_out_t  e;
    b          = w.text_byte;
    fin        = w.final_byte;
    is_sep     = (b == separator) && (b != QUOTE_BYTE) && (b != CR_BYTE) && (b != LF_BYTE);
    ends       = is_sep || (b == CR_BYTE) || (b == LF_BYTE);
    stray_done = 1'b0;
    byte_events.delete();

    if (scan == MODE_CR && b == LF_BYTE) begin
      scan = MODE_ROW;
    end else begin
      case (scan)
        MODE_CR, MODE_ROW, MODE_FIELD: begin
          if (b == QUOTE_BYTE) begin
            scan = MODE_QUO;
          end else if (ends) begin
            close_field(b);
          end else begin
            add_event(make_event(KIND_CHAR, b));
            scan = MODE_UNQ;
          end
        end
        MODE_UNQ: begin
          if (ends) close_field(b);
          else add_event(make_event(KIND_CHAR, b));
        end
        MODE_QUO: begin
          if (b == QUOTE_BYTE) scan = MODE_QQ;
          else add_event(make_event(KIND_CHAR, b));
        end
        MODE_QQ: begin
          if (b == QUOTE_BYTE) begin
            // doubled quote inside quotes gives one quote character
            add_event(make_event(KIND_CHAR, b));
            scan = MODE_QUO;
          end else if (ends) begin
            close_field(b);
          end else if (fin) begin
            // stray byte on the last word stays in the quoted field
            add_event(make_event(KIND_CHAR, b));
            add_event(make_event(KIND_ROW, 8'd0));
            stray_done = 1'b1;
          end else begin
            add_event(make_event(KIND_FIELD, 8'd0));
            add_event(make_event(KIND_CHAR, b));
            scan = MODE_UNQ;
          end
        end
        default: scan = MODE_ROW;
      endcase
    end

    // Last word of the text closes any open field
    if (fin) begin
      if (!stray_done && (scan == MODE_FIELD || scan == MODE_UNQ ||
                          scan == MODE_QUO || scan == MODE_QQ))
        add_event(make_event(KIND_ROW, 8'd0));
      scan = MODE_ROW;
    end

    for (int i = 0; i < byte_events.size(); i++) begin
      e               = byte_events[i];
      e.run_last      = (i == byte_events.size() - 1);
      expected_events = {expected_events, e};
    end
  endtask

  // Compare results first, then predict for the word taken at the same edge
  always @(posedge clk) begin : watch
    csvt_out_t want;
    if (!rst_n) begin
      separator = SEP_RESET;
      scan      = MODE_ROW;
      expected_events.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("%0t: unexpected event kind=%0d char=%02h last=%0b", $realtime,
                     out_data.event_kind, out_data.field_char, out_data.run_last);
        end else begin
          want = expected_events.pop_front();
          if (out_data !== want) begin
            fail_total++;
            if (fail_total <= 10)
              $display("%0t: exp kind=%0d char=%02h last=%0b, got kind=%0d char=%02h last=%0b",
                       $realtime, want.event_kind, want.field_char, want.run_last,
                       out_data.event_kind, out_data.field_char, out_data.run_last);
          end
        end
      end
      if (in_valid && in_ready) predict_events(in_data);
      if (cfg_we) separator = cfg_wdata;
    end
  end

endmodule

// ===== tb/sv/tb_csv_field_tokenizer_unit.sv =====
// Testbench top for csv_field_tokenizer_unit: drives text words and separator
// writes, stalls the result side, and gives the verdict from csvt_event_checker.
// Depends on csvt_pkg, csv_field_tokenizer_unit and csvt_event_checker.
module tb_csv_field_tokenizer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import csvt_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  csvt_in_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  csvt_out_t  out_data;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  int         fail_count;
  int         pending;
  int         in_idle_pct = 35;
  int         out_idle_pct = 35;
  int         words_sent = 0;
  logic [7:0] cur_sep = SEP_RESET;
  logic [7:0] text_buf[$];

  csv_field_tokenizer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  csvt_event_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  // Stall the result side at random
  always @(negedge clk) begin
    if (out_idle_pct == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Hard stop for a hung run
  initial begin
    #400_000;
    $display("FAILURE");
    $finish;
  end

  // Offer one word, with random idle cycles before it; returns at a falling edge
  task automatic send_word(input logic [7:0] b, input logic fin);
    csvt_in_t w;
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    w.text_byte  = b;
    w.final_byte = fin;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input string s, input logic fin_last);
    for (int i = 0; i < s.len(); i++)
      send_word(s[i], fin_last && (i == s.len() - 1));
  endtask

  // Hold the sender until every expected event has come, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_separator(input logic [7:0] sep);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= sep;
    @(negedge clk);
    cfg_we  <= 1'b0;
    cur_sep = sep;
  endtask

  // Append one byte to the text being built
  function automatic void put_byte(input logic [7:0] c);
    text_buf = {text_buf, c};
  endfunction

  // Field content byte with no special meaning outside quotes
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == QUOTE_BYTE || c == CR_BYTE || c == LF_BYTE || c == cur_sep);
    return c;
  endfunction

  // Any byte, biased toward the ones that steer the scanner
  function automatic logic [7:0] steering_char();
    case ($urandom_range(7))
      0: return QUOTE_BYTE;
      1: return CR_BYTE;
      2: return LF_BYTE;
      3: return cur_sep;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic add_field();
    int len;
    logic [7:0] c;
    len = $urandom_range(5);
    if ($urandom_range(99) < 40) begin
      put_byte(QUOTE_BYTE);
      repeat (len) begin
        c = steering_char();
        put_byte(c);
        if (c == QUOTE_BYTE) put_byte(c);
      end
      put_byte(QUOTE_BYTE);
      // stray byte after the closing quote
      if ($urandom_range(99) < 20) put_byte(plain_char());
    end else begin
      repeat (len) put_byte(plain_char());
    end
  endtask

  // Build one text of rows, some with a stray byte after a closing quote, cut short now and then
  task automatic build_rows();
    int rows;
    int fields;
    int keep;
    text_buf.delete();
    rows = $urandom_range(1, 3);
    repeat (rows) begin
      fields = $urandom_range(1, 4);
      for (int f = 0; f < fields; f++) begin
        if (f != 0) put_byte(cur_sep);
        add_field();
      end
      case ($urandom_range(2))
        0: put_byte(CR_BYTE);
        1: put_byte(LF_BYTE);
        default: begin
          put_byte(CR_BYTE);
          put_byte(LF_BYTE);
        end
      endcase
    end
    if ($urandom_range(99) < 30) begin
      keep = $urandom_range(1, text_buf.size());
      while (text_buf.size() > keep) void'(text_buf.pop_back());
    end
  endtask

  task automatic run_phase(input int count);
    int stop_at;
    int len;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      if ($urandom_range(99) < 85) begin
        build_rows();
        for (int i = 0; i < text_buf.size(); i++)
          send_word(text_buf[i], i == text_buf.size() - 1);
      end else begin
        // noise: random bytes with the last-word flag set at random
        len = $urandom_range(1, 8);
        repeat (len) send_word(steering_char(), $urandom_range(7) == 0);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words under the reset separator
    send_string("a,b\r\n", 1'b0);
    send_string("\"x\"\"\"\n", 1'b0);
    send_string("\"q\"z,", 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_string("\rc", 1'b0);
    send_string(",", 1'b1);
    send_string("\"\"k", 1'b1);
    send_string("\"", 1'b1);
    send_string("\n", 1'b1);
    send_string("x\r", 1'b1);

    // Long stretch with no idling on either side
    drain();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_phase(100);

    in_idle_pct  = 35;
    out_idle_pct = 35;
    run_phase(90);
    set_separator(8'h3B);
    run_phase(90);
    set_separator(8'h00);
    run_phase(90);
    set_separator(8'hFF);
    run_phase(90);
    set_separator(8'h09);
    run_phase(80);
    set_separator(QUOTE_BYTE);
    run_phase(60);
    set_separator(CR_BYTE);
    run_phase(60);
    set_separator(SEP_RESET);
    run_phase(60);

    drain();
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
